[rtl/core/rgbedd_pkg.sv]
// Shared types and constants for the RGB error-diffusion dither unit.
// No dependencies; imported by the lane and the top level.
`default_nettype none

package rgbedd_pkg;

  // Pixel channel width and default geometry limits
  localparam int PIX_W          = 8;
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_CHANNELS   = 3;

  // Configuration port geometry
  localparam int CFG_AW         = 4;
  localparam int CFG_DW         = 32;

  // Register field widths
  localparam int BITS_KEPT_W    = 3;
  localparam int IMG_WIDTH_W    = 12;
  localparam int IMG_HEIGHT_W   = 16;

  // Register reset values
  localparam logic [BITS_KEPT_W-1:0]  BITS_KEPT_RST  = 3'd1;
  localparam logic [IMG_WIDTH_W-1:0]  IMG_WIDTH_RST  = 12'd640;
  localparam logic [IMG_HEIGHT_W-1:0] IMG_HEIGHT_RST = 16'd480;

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_BITS_KEPT  = 2'd0,
    REG_IMG_WIDTH  = 2'd1,
    REG_IMG_HEIGHT = 2'd2
  } cfg_reg_t;

  // Where the pixel sits in the frame
  typedef struct packed {
    logic first_row;
    logic last_row;
    logic last_col;
  } pos_flags_t;

endpackage

`default_nettype wire

[rtl/core/rgbedd_line_store.sv]
// Line store of next-row error sums, one word per column, all channels.
// Clears itself after reset, forwards same-cycle and pending writes to the read.
// Standalone module, no package dependency.
`default_nettype none

module rgbedd_line_store #(
  parameter int MAX_WIDTH = 2048,
  parameter int DW        = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  output logic                         ready,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output logic [DW-1:0]                rd_data,
  input  logic                         main_we,
  input  logic [$clog2(MAX_WIDTH)-1:0] main_addr,
  input  logic [DW-1:0]                main_wdata,
  input  logic                         tail_we,
  input  logic [$clog2(MAX_WIDTH)-1:0] tail_addr,
  input  logic [DW-1:0]                tail_wdata
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [DW-1:0] mem [MAX_WIDTH];

  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  logic          tail_pend_r, tail_pend_nxt;
  logic [AW-1:0] tail_addr_r;
  logic [DW-1:0] tail_data_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  logic          fwd_hit, fwd_hit_r;
  logic [DW-1:0] fwd_data, fwd_data_r;
  logic [DW-1:0] mem_q_r;

  assign ready = !clr_busy_r;

  // Clearing sweep after reset, one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == AW'(MAX_WIDTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // Single write port: sweep, then column write, then deferred end-of-row write
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = main_addr;
    wr_data = main_wdata;
    if (clr_busy_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else if (main_we) begin
      wr_en   = 1'b1;
    end else if (tail_pend_r) begin
      wr_en   = 1'b1;
      wr_addr = tail_addr_r;
      wr_data = tail_data_r;
    end
  end

  // End-of-row word waits here until the port is free
  assign tail_pend_nxt = tail_we | (tail_pend_r & (main_we | clr_busy_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_pend_r <= 1'b0;
    end else begin
      tail_pend_r <= tail_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tail_we) begin
      tail_addr_r <= tail_addr;
      tail_data_r <= tail_wdata;
    end
  end

  // Newest matching write wins over the array contents
  always_comb begin
    fwd_hit  = 1'b0;
    fwd_data = main_wdata;
    if (main_we && (main_addr == rd_addr)) begin
      fwd_hit  = 1'b1;
    end else if (tail_we && (tail_addr == rd_addr)) begin
      fwd_hit  = 1'b1;
      fwd_data = tail_wdata;
    end else if (tail_pend_r && (tail_addr_r == rd_addr)) begin
      fwd_hit  = 1'b1;
      fwd_data = tail_data_r;
    end
  end

  // Array write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_hit_r  <= fwd_hit;
      fwd_data_r <= fwd_data;
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : mem_q_r;

endmodule

`default_nettype wire

[rtl/core/rgbedd_lane.sv]
// One colour channel of the dither: quantise, split the error, hold the carries.
// Depends on rgbedd_pkg for the pixel width and the position flags.
`default_nettype none

module rgbedd_lane import rgbedd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  pos_flags_t             flags,
  input  logic [BITS_KEPT_W-1:0] bits_kept,
  input  logic [PIX_W-1:0]       pix,
  input  logic [PIX_W-1:0]       below,
  output logic [PIX_W-1:0]       q,
  output logic [PIX_W-1:0]       main_wdata,
  output logic [PIX_W-1:0]       tail_wdata
);

  logic [PIX_W-1:0] carry_r, carry_nxt;
  logic [PIX_W-1:0] pa_r, pa_nxt;
  logic [PIX_W-1:0] pb_r, pb_nxt;

  logic [PIX_W+1:0] sum;
  logic [PIX_W-1:0] v, lowmask, e;
  logic [PIX_W+2:0] e7x, e5x, e3x;
  logic [PIX_W-1:0] e7, e5, e3, e1;

  function automatic logic [PIX_W-1:0] sat8(input logic [PIX_W:0] a);
    sat8 = a[PIX_W] ? {PIX_W{1'b1}} : a[PIX_W-1:0];
  endfunction

  // Diffused input, saturated, then truncated to the kept bits
  always_comb begin
    sum = (PIX_W+2)'(pix) + (PIX_W+2)'(carry_r)
        + (flags.first_row ? '0 : (PIX_W+2)'(below));
    v = (sum > (PIX_W+2)'(255)) ? {PIX_W{1'b1}} : sum[PIX_W-1:0];
    lowmask = {PIX_W{1'b1}} >> bits_kept;
    q = v & ~lowmask;
    e = v & lowmask;
  end

  // Error shares in sixteenths, truncated
  always_comb begin
    e7x = (PIX_W+3)'(e) * (PIX_W+3)'(7);
    e5x = (PIX_W+3)'(e) * (PIX_W+3)'(5);
    e3x = (PIX_W+3)'(e) * (PIX_W+3)'(3);
    e7  = PIX_W'(e7x >> 4);
    e5  = PIX_W'(e5x >> 4);
    e3  = PIX_W'(e3x >> 4);
    e1  = e >> 4;
  end

  // Words for the line store: below-left finished, and the row end
  assign main_wdata = sat8((PIX_W+1)'(pb_r) + (PIX_W+1)'(e3));
  assign tail_wdata = sat8((PIX_W+1)'(pa_r) + (PIX_W+1)'(e5));

  always_comb begin
    carry_nxt = flags.last_col ? '0 : e7;
    if (flags.last_row) begin
      pa_nxt = '0;
      pb_nxt = '0;
    end else begin
      pa_nxt = flags.last_col ? '0 : e1;
      pb_nxt = flags.last_col ? '0 : tail_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= '0;
      pa_r    <= '0;
      pb_r    <= '0;
    end else if (adv) begin
      carry_r <= carry_nxt;
      pa_r    <= pa_nxt;
      pb_r    <= pb_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/rgb_error_diffusion_dither_unit.sv]
// RGB error-diffusion dither, one lane per channel behind a shared line store.
// Each input is registered in stage A, then in the output register (out_tvalid).
// Throughput: 1 pixel per cycle unless stalled; each carry loop is one register.
// Reset: config registers to 1 / 640 / 480, counters and carries to zero, then a
// clearing pass over all MAX_WIDTH entries (2048 by default) with in_tready low.
// Depends on rgbedd_pkg, rgbedd_line_store and rgbedd_lane.
`default_nettype none

module rgb_error_diffusion_dither_unit import rgbedd_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int CHANNELS  = DEF_CHANNELS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input pixels
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [CHANNELS*PIX_W-1:0] in_tdata,    // red_in, green_in, blue_in
  // quantised pixels
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [CHANNELS*PIX_W-1:0] out_tdata,   // red_out, green_out, blue_out
  output logic                      out_tlast,   // end_of_frame
  // configuration
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [CFG_AW-1:0]         cfg_paddr,
  input  logic [CFG_DW-1:0]         cfg_pwdata,
  output logic [CFG_DW-1:0]         cfg_prdata,
  output logic                      cfg_pready
);

  localparam int DW = CHANNELS * PIX_W;
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = (AW + 1 > IMG_WIDTH_W) ? AW + 1 : IMG_WIDTH_W;

  logic [BITS_KEPT_W-1:0]  bits_kept_r;
  logic [IMG_WIDTH_W-1:0]  img_width_r;
  logic [IMG_HEIGHT_W-1:0] img_height_r;
  logic                    cfg_wr;
  cfg_reg_t                cfg_sel;

  logic [CW-1:0]           width_ext;
  logic [AW-1:0]           wm1;
  logic [IMG_HEIGHT_W-1:0] hm1;

  logic [AW-1:0]           col_r, col_nxt;
  logic [IMG_HEIGHT_W-1:0] row_r, row_nxt;
  logic [AW-1:0]           cur_x;
  pos_flags_t              cur_flags;

  logic                    in_acc;
  logic                    a_valid_r, a_adv;
  logic [DW-1:0]           a_pix_r;
  pos_flags_t              a_flags_r;
  logic [AW-1:0]           a_x_r;

  logic                    ls_ready;
  logic [DW-1:0]           ls_rd_data;
  logic                    main_we, tail_we;
  logic [DW-1:0]           main_wdata, tail_wdata;
  logic [DW-1:0]           q_all;

  logic                    out_valid_r;
  logic [DW-1:0]           out_data_r;
  logic                    out_last_r;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_kept_r  <= BITS_KEPT_RST;
      img_width_r  <= IMG_WIDTH_RST;
      img_height_r <= IMG_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_BITS_KEPT:  bits_kept_r  <= cfg_pwdata[BITS_KEPT_W-1:0];
        REG_IMG_WIDTH:  img_width_r  <= cfg_pwdata[IMG_WIDTH_W-1:0];
        REG_IMG_HEIGHT: img_height_r <= cfg_pwdata[IMG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_BITS_KEPT:  cfg_prdata = CFG_DW'(bits_kept_r);
      REG_IMG_WIDTH:  cfg_prdata = CFG_DW'(img_width_r);
      REG_IMG_HEIGHT: cfg_prdata = CFG_DW'(img_height_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // Effective geometry: width in 1..MAX_WIDTH, height at least 1
  assign width_ext = CW'(img_width_r);

  always_comb begin
    if (img_width_r == '0) begin
      wm1 = '0;
    end else if (width_ext > CW'(MAX_WIDTH)) begin
      wm1 = AW'(MAX_WIDTH - 1);
    end else begin
      wm1 = AW'(width_ext - CW'(1));
    end
  end

  assign hm1 = (img_height_r == '0) ? '0 : img_height_r - 1'b1;

  // Position of the incoming pixel
  always_comb begin
    cur_flags.last_col  = (col_r >= wm1);
    cur_flags.last_row  = (row_r >= hm1);
    cur_flags.first_row = (row_r == '0);
    cur_x               = cur_flags.last_col ? wm1 : col_r;
    if (cur_flags.last_col) begin
      col_nxt = '0;
      row_nxt = cur_flags.last_row ? '0 : row_r + 1'b1;
    end else begin
      col_nxt = cur_x + 1'b1;
      row_nxt = row_r;
    end
  end

  // Handshake: stage A moves on whenever the output register can take it
  assign a_adv     = a_valid_r & (!out_valid_r | out_tready);
  assign in_tready = ls_ready & (!a_valid_r | a_adv);
  assign in_acc    = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      a_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (in_acc) begin
        a_valid_r <= 1'b1;
      end else if (a_adv) begin
        a_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_pix_r   <= in_tdata;
      a_flags_r <= cur_flags;
      a_x_r     <= cur_x;
    end
  end

  // Line store writes for the row below
  assign main_we = a_adv & !a_flags_r.last_row & (a_x_r != '0);
  assign tail_we = a_adv & !a_flags_r.last_row & a_flags_r.last_col;

  rgbedd_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .DW        (DW)
  ) u_line_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .ready      (ls_ready),
    .rd_en      (in_acc),
    .rd_addr    (cur_x),
    .rd_data    (ls_rd_data),
    .main_we    (main_we),
    .main_addr  (a_x_r - 1'b1),
    .main_wdata (main_wdata),
    .tail_we    (tail_we),
    .tail_addr  (a_x_r),
    .tail_wdata (tail_wdata)
  );

  // One lane per channel
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    rgbedd_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (a_adv),
      .flags      (a_flags_r),
      .bits_kept  (bits_kept_r),
      .pix        (a_pix_r[g*PIX_W +: PIX_W]),
      .below      (ls_rd_data[g*PIX_W +: PIX_W]),
      .q          (q_all[g*PIX_W +: PIX_W]),
      .main_wdata (main_wdata[g*PIX_W +: PIX_W]),
      .tail_wdata (tail_wdata[g*PIX_W +: PIX_W])
    );
  end

  // Merge the lanes into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      out_data_r <= q_all;
      out_last_r <= a_flags_r.last_col & a_flags_r.last_row;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

[rtl/core/rgbedd_chk.sv]
// Port-level checks for the dither unit, attached to the top level by bind.
// Depends only on the top level's ports.
`default_nettype none

module rgbedd_chk #(
  parameter int DW = 24
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_tvalid,
  input logic          in_tready,
  input logic          out_tvalid,
  input logic          out_tready,
  input logic [DW-1:0] out_tdata,
  input logic          out_tlast
);

  // A stalled result holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // The line store sweep keeps the input closed right after reset
  a_clear_closed: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input open during line store clear");

  // A fresh result comes from an earlier accepted input transaction
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without matching input transaction");

endmodule

bind rgb_error_diffusion_dither_unit rgbedd_chk #(
  .DW (CHANNELS * 8)
) u_rgbedd_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
